/* hdl/wcs_pkg.sv */
// ----------------------------------------------------------------------------
// wcs_pkg
// Shared types, constants and helper functions of the wall column shader:
// register indexes, reset values, the color palette and the cell codes.
// ----------------------------------------------------------------------------
package wcs_pkg;

  // Widths fixed by the item and register formats.
  localparam int HEIGHT_BITS_DEF = 12;
  localparam int DIST_W          = 16;
  localparam int GAIN_W          = 16;
  localparam int SHADE_W         = 9;
  localparam int SHADE_Q_W       = 8;
  localparam int CODE_W          = 8;
  localparam int CHAN_W          = 8;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_IDX_W       = 3;

  // Arithmetic constants.
  localparam int HEIGHT_MIN  = 2;
  localparam int SIDE_NUM    = 7;
  localparam int DIV10_RECIP = 6554;
  localparam logic [SHADE_W-1:0] SHADE_ONE = 9'd256;

  // Reset values of the configuration registers.
  localparam int SCREEN_HEIGHT_RST = 480;
  localparam int HEIGHT_MARGIN_RST = 0;
  localparam logic [GAIN_W-1:0]  HEIGHT_GAIN_RST = 16'd256;
  localparam logic [GAIN_W-1:0]  SHADE_GAIN_RST  = 16'd768;
  localparam logic [SHADE_W-1:0] MIN_SHADE_RST   = 9'd26;
  localparam logic [DIST_W-1:0]  VIEW_LIMIT_RST  = 16'd5120;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_HEIGHT = 3'd0,
    CFG_HEIGHT_MARGIN = 3'd1,
    CFG_HEIGHT_GAIN   = 3'd2,
    CFG_SHADE_GAIN    = 3'd3,
    CFG_MIN_SHADE     = 3'd4,
    CFG_VIEW_LIMIT    = 3'd5
  } cfg_idx_t;

  // Map cell character codes.
  localparam logic [CODE_W-1:0] CODE_WALL   = 8'h23;
  localparam logic [CODE_W-1:0] CODE_YELLOW = 8'h31;
  localparam logic [CODE_W-1:0] CODE_RED    = 8'h32;
  localparam logic [CODE_W-1:0] CODE_GREEN  = 8'h33;
  localparam logic [CODE_W-1:0] CODE_BLUE   = 8'h34;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } rgb_t;

  localparam rgb_t COL_WALL   = '{r: 8'd72,  g: 8'd78,  b: 8'd96};
  localparam rgb_t COL_BG     = '{r: 8'd10,  g: 8'd10,  b: 8'd20};
  localparam rgb_t COL_SEP    = '{r: 8'd100, g: 8'd93,  b: 8'd120};
  localparam rgb_t COL_YELLOW = '{r: 8'd199, g: 8'd191, b: 8'd80};
  localparam rgb_t COL_RED    = '{r: 8'd133, g: 8'd9,   b: 8'd18};
  localparam rgb_t COL_GREEN  = '{r: 8'd4,   g: 8'd130, b: 8'd29};
  localparam rgb_t COL_BLUE   = '{r: 8'd0,   g: 8'd26,  b: 8'd110};

  // Per-item flags that travel down the pipeline with the item.
  typedef struct packed {
    logic [CODE_W-1:0] cell_code;
    logic              side_hit;
    logic              beyond;      // distance at or past the view limit
    logic              height_ovf;  // height quotient exceeds the height range
    logic              shade_sat;   // shade factor saturates at 1.0
  } tag_t;

  // Base color of a hit cell.
  function automatic rgb_t base_colour(input logic [CODE_W-1:0] code);
    rgb_t c;
    case (code)
      CODE_WALL:   c = COL_WALL;
      CODE_YELLOW: c = COL_YELLOW;
      CODE_RED:    c = COL_RED;
      CODE_GREEN:  c = COL_GREEN;
      CODE_BLUE:   c = COL_BLUE;
      default:     c = COL_SEP;
    endcase
    return c;
  endfunction

  // Exact floor(x / 10) for x below 2048, by a reciprocal multiply.
  function automatic logic [CHAN_W-1:0] div10(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'(DIV10_RECIP);
    return p[23:16];
  endfunction

endpackage

/* hdl/wcs_front.sv */
// ----------------------------------------------------------------------------
// wcs_front
// Input register and projection multiply, then the saturation checks that
// decide whether each quotient overflows before the divider runs.
// ----------------------------------------------------------------------------
module wcs_front #(
  parameter int HEIGHT_BITS = wcs_pkg::HEIGHT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic [wcs_pkg::CODE_W-1:0]         in_cell_code,
  input  logic                               in_side_hit,
  input  logic [wcs_pkg::DIST_W-1:0]         in_distance,
  input  logic [HEIGHT_BITS-1:0]             screen_height,
  input  logic [wcs_pkg::GAIN_W-1:0]         height_gain,
  input  logic [wcs_pkg::GAIN_W-1:0]         shade_gain,
  input  logic [wcs_pkg::DIST_W-1:0]         view_limit,
  output logic                               out_valid,
  output wcs_pkg::tag_t                      out_tag,
  output logic [wcs_pkg::DIST_W-1:0]         out_distance,
  output logic [HEIGHT_BITS+wcs_pkg::GAIN_W-1:0] out_num
);

  localparam int NUM_W = HEIGHT_BITS + wcs_pkg::GAIN_W;

  logic                        v1_r;
  wcs_pkg::tag_t               tag1_r;
  wcs_pkg::tag_t               tag1_nxt;
  logic [wcs_pkg::DIST_W-1:0]  d1_r;
  logic [NUM_W-1:0]            num1_r;
  logic [NUM_W-1:0]            num1_nxt;

  logic                        v2_r;
  wcs_pkg::tag_t               tag2_r;
  wcs_pkg::tag_t               tag2_nxt;
  logic [wcs_pkg::DIST_W-1:0]  d2_r;
  logic [NUM_W-1:0]            num2_r;

  // Stage one: capture the item, test the view limit and form the numerator.
  always_comb begin
    tag1_nxt            = '0;
    tag1_nxt.cell_code  = in_cell_code;
    tag1_nxt.side_hit   = in_side_hit;
    tag1_nxt.beyond     = (in_distance >= view_limit);
    num1_nxt            = NUM_W'(screen_height) * NUM_W'(height_gain);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    tag1_r <= tag1_nxt;
    d1_r   <= in_distance;
    num1_r <= num1_nxt;
  end

  // Stage two: a quotient saturates when the top part of its dividend
  // already reaches the divisor. Zero distance saturates both.
  always_comb begin
    tag2_nxt            = tag1_r;
    tag2_nxt.height_ovf = (num1_r[NUM_W-1:HEIGHT_BITS] >= d1_r);
    tag2_nxt.shade_sat  = (shade_gain >= d1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    tag2_r <= tag2_nxt;
    d2_r   <= d1_r;
    num2_r <= num1_r;
  end

  assign out_valid    = v2_r;
  assign out_tag      = tag2_r;
  assign out_distance = d2_r;
  assign out_num      = num2_r;

endmodule

/* hdl/wcs_div_pipe.sv */
// ----------------------------------------------------------------------------
// wcs_div_pipe
// Pipelined restoring divider with two lanes sharing one divisor: the height
// lane yields HEIGHT_BITS quotient bits, the shade lane eight. One quotient
// bit per lane per stage; the shade lane holds once its bits are done.
// ----------------------------------------------------------------------------
module wcs_div_pipe #(
  parameter int HEIGHT_BITS = wcs_pkg::HEIGHT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  wcs_pkg::tag_t                          in_tag,
  input  logic [wcs_pkg::DIST_W-1:0]             in_distance,
  input  logic [HEIGHT_BITS+wcs_pkg::GAIN_W-1:0] in_num,
  input  logic [wcs_pkg::GAIN_W-1:0]             shade_gain,
  output logic                                   out_valid,
  output wcs_pkg::tag_t                          out_tag,
  output logic [HEIGHT_BITS-1:0]                 out_height_q,
  output logic [wcs_pkg::SHADE_Q_W-1:0]          out_shade_q
);

  localparam int NUM_W = HEIGHT_BITS + wcs_pkg::GAIN_W;
  localparam int REM_W = wcs_pkg::DIST_W;

  typedef struct packed {
    logic                         valid;
    wcs_pkg::tag_t                tag;
    logic [REM_W-1:0]             d;
    logic [HEIGHT_BITS-1:0]       lo;
    logic [REM_W-1:0]             hrem;
    logic [HEIGHT_BITS-1:0]       hq;
    logic [REM_W-1:0]             srem;
    logic [wcs_pkg::SHADE_Q_W-1:0] sq;
  } dstage_t;

  dstage_t stg_in  [HEIGHT_BITS];
  dstage_t stg_nxt [HEIGHT_BITS];
  dstage_t stg_r   [HEIGHT_BITS];

  // Entry: the height remainder starts from the top of the numerator, the
  // shade remainder from the shading gain.
  always_comb begin
    stg_in[0]       = '0;
    stg_in[0].valid = in_valid;
    stg_in[0].tag   = in_tag;
    stg_in[0].d     = in_distance;
    stg_in[0].lo    = in_num[HEIGHT_BITS-1:0];
    stg_in[0].hrem  = in_num[NUM_W-1:HEIGHT_BITS];
    stg_in[0].srem  = shade_gain;
  end

  for (genvar i = 0; i < HEIGHT_BITS; i++) begin : g_stage
    logic [REM_W:0] htry;
    logic           hge;
    logic [REM_W:0] stry;
    logic           sge;

    if (i > 0) begin : g_link
      assign stg_in[i] = stg_r[i-1];
    end

    // One restoring step per lane.
    always_comb begin
      htry = {stg_in[i].hrem, stg_in[i].lo[HEIGHT_BITS-1]};
      hge  = (htry >= {1'b0, stg_in[i].d});
      stry = {stg_in[i].srem, 1'b0};
      sge  = (stry >= {1'b0, stg_in[i].d});

      stg_nxt[i]      = stg_in[i];
      stg_nxt[i].lo   = {stg_in[i].lo[HEIGHT_BITS-2:0], 1'b0};
      stg_nxt[i].hq   = {stg_in[i].hq[HEIGHT_BITS-2:0], hge};
      stg_nxt[i].hrem = hge ? REM_W'(htry - {1'b0, stg_in[i].d}) : htry[REM_W-1:0];
      if (i < wcs_pkg::SHADE_Q_W) begin
        stg_nxt[i].sq   = {stg_in[i].sq[wcs_pkg::SHADE_Q_W-2:0], sge};
        stg_nxt[i].srem = sge ? REM_W'(stry - {1'b0, stg_in[i].d}) : stry[REM_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_r[i].valid <= 1'b0;
      end else begin
        stg_r[i] <= stg_nxt[i];
      end
    end
  end

  assign out_valid    = stg_r[HEIGHT_BITS-1].valid;
  assign out_tag      = stg_r[HEIGHT_BITS-1].tag;
  assign out_height_q = stg_r[HEIGHT_BITS-1].hq;
  assign out_shade_q  = stg_r[HEIGHT_BITS-1].sq;

endmodule

/* hdl/wcs_back.sv */
// ----------------------------------------------------------------------------
// wcs_back
// Height clamping and color shading: one stage clamps the height and scales
// the base color, the next applies side darkening, the dark cutoff and the
// view limit, and drives the result registers.
// ----------------------------------------------------------------------------
module wcs_back #(
  parameter int HEIGHT_BITS = wcs_pkg::HEIGHT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  wcs_pkg::tag_t                     in_tag,
  input  logic [HEIGHT_BITS-1:0]            in_height_q,
  input  logic [wcs_pkg::SHADE_Q_W-1:0]     in_shade_q,
  input  logic [HEIGHT_BITS-1:0]            screen_height,
  input  logic [HEIGHT_BITS-1:0]            height_margin,
  input  logic [wcs_pkg::SHADE_W-1:0]       min_shade,
  output logic                              out_valid,
  output logic [wcs_pkg::CHAN_W-1:0]        out_red,
  output logic [wcs_pkg::CHAN_W-1:0]        out_green,
  output logic [wcs_pkg::CHAN_W-1:0]        out_blue,
  output logic [HEIGHT_BITS-1:0]            out_column_height
);

  localparam int PROD_W = wcs_pkg::CHAN_W + wcs_pkg::SHADE_W;
  localparam logic signed [HEIGHT_BITS:0] H_MIN = (HEIGHT_BITS+1)'(wcs_pkg::HEIGHT_MIN);

  // Scaled channel, then side darkening by seven tenths.
  function automatic logic [wcs_pkg::CHAN_W-1:0] shade_chan(
    input logic [PROD_W-1:0] p,
    input logic              side
  );
    logic [wcs_pkg::CHAN_W-1:0] v;
    logic [10:0]                v7;
    v  = p[wcs_pkg::CHAN_W+7:8];
    v7 = 11'(v) * 11'(wcs_pkg::SIDE_NUM);
    return side ? wcs_pkg::div10(v7) : v;
  endfunction

  logic signed [HEIGHT_BITS:0]   cap;
  logic signed [HEIGHT_BITS:0]   hq_s;
  logic signed [HEIGHT_BITS:0]   hcap;
  logic [HEIGHT_BITS-1:0]        h_nxt;
  logic [wcs_pkg::SHADE_W-1:0]   m_nxt;
  wcs_pkg::rgb_t                 base;

  logic                          f1_valid_r;
  wcs_pkg::tag_t                 f1_tag_r;
  logic [HEIGHT_BITS-1:0]        f1_h_r;
  logic [wcs_pkg::SHADE_W-1:0]   f1_m_r;
  logic [PROD_W-1:0]             f1_pr_r;
  logic [PROD_W-1:0]             f1_pg_r;
  logic [PROD_W-1:0]             f1_pb_r;

  wcs_pkg::rgb_t                 col_nxt;
  logic [HEIGHT_BITS-1:0]        oh_nxt;
  logic                          ov_r;
  wcs_pkg::rgb_t                 col_r;
  logic [HEIGHT_BITS-1:0]        oh_r;

  // Height: take the cap on overflow or when the quotient exceeds it, then
  // hold at least the minimum height. Shade factor saturates at 1.0.
  always_comb begin
    cap  = $signed({1'b0, screen_height}) - $signed({1'b0, height_margin});
    hq_s = $signed({1'b0, in_height_q});
    if (in_tag.height_ovf || (hq_s > cap)) begin
      hcap = cap;
    end else begin
      hcap = hq_s;
    end
    if (hcap < H_MIN) begin
      hcap = H_MIN;
    end
    h_nxt = hcap[HEIGHT_BITS-1:0];
    m_nxt = in_tag.shade_sat ? wcs_pkg::SHADE_ONE : {1'b0, in_shade_q};
    base  = wcs_pkg::base_colour(in_tag.cell_code);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= in_valid;
    end
    f1_tag_r <= in_tag;
    f1_h_r   <= h_nxt;
    f1_m_r   <= m_nxt;
    f1_pr_r  <= PROD_W'(base.r) * PROD_W'(m_nxt);
    f1_pg_r  <= PROD_W'(base.g) * PROD_W'(m_nxt);
    f1_pb_r  <= PROD_W'(base.b) * PROD_W'(m_nxt);
  end

  // Final color and height, with the dark cutoff and the view limit.
  always_comb begin
    col_nxt.r = shade_chan(f1_pr_r, f1_tag_r.side_hit);
    col_nxt.g = shade_chan(f1_pg_r, f1_tag_r.side_hit);
    col_nxt.b = shade_chan(f1_pb_r, f1_tag_r.side_hit);
    oh_nxt    = f1_h_r;
    if (f1_tag_r.beyond) begin
      col_nxt = wcs_pkg::COL_BG;
      oh_nxt  = screen_height;
    end else if (f1_m_r < min_shade) begin
      col_nxt = wcs_pkg::COL_BG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= f1_valid_r;
    end
    col_r <= col_nxt;
    oh_r  <= oh_nxt;
  end

  assign out_valid         = ov_r;
  assign out_red           = col_r.r;
  assign out_green         = col_r.g;
  assign out_blue          = col_r.b;
  assign out_column_height = oh_r;

endmodule

/* hdl/wall_column_shader_unit.sv */
// ----------------------------------------------------------------------------
// wall_column_shader_unit
// Turns one cast ray into the color and height of one screen column.
// ----------------------------------------------------------------------------
// The unit takes one ray item in every clock cycle while busy is low and
// gives its column on out_red, out_green, out_blue and out_column_height,
// marked by out_valid for exactly one cycle; results are not held, so the
// receiver must take each one as it appears. The pipelined divider forms
// one quotient bit per stage for the height quotient and sits between two
// input stages and two shading stages. busy is high while reset is held
// and in the cycle after its release.
// Configuration registers may be written only while no item is in flight.
module wall_column_shader_unit #(
  parameter int HEIGHT_BITS = wcs_pkg::HEIGHT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [wcs_pkg::CODE_W-1:0]          in_cell_code,
  input  logic                                in_side_hit,
  input  logic [wcs_pkg::DIST_W-1:0]          in_distance,
  output logic                                out_valid,
  output logic [wcs_pkg::CHAN_W-1:0]          out_red,
  output logic [wcs_pkg::CHAN_W-1:0]          out_green,
  output logic [wcs_pkg::CHAN_W-1:0]          out_blue,
  output logic [HEIGHT_BITS-1:0]              out_column_height,
  input  logic                                cfg_we,
  input  logic [wcs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wcs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int NUM_W   = HEIGHT_BITS + wcs_pkg::GAIN_W;
  localparam int LATENCY = HEIGHT_BITS + 4;

  logic [HEIGHT_BITS-1:0]          screen_height_r;
  logic [HEIGHT_BITS-1:0]          height_margin_r;
  logic [wcs_pkg::GAIN_W-1:0]      height_gain_r;
  logic [wcs_pkg::GAIN_W-1:0]      shade_gain_r;
  logic [wcs_pkg::SHADE_W-1:0]     min_shade_r;
  logic [wcs_pkg::DIST_W-1:0]      view_limit_r;
  logic                            busy_r;
  logic                            in_acc;

  logic                            fr_valid;
  wcs_pkg::tag_t                   fr_tag;
  logic [wcs_pkg::DIST_W-1:0]      fr_distance;
  logic [NUM_W-1:0]                fr_num;

  logic                            dv_valid;
  wcs_pkg::tag_t                   dv_tag;
  logic [HEIGHT_BITS-1:0]          dv_height_q;
  logic [wcs_pkg::SHADE_Q_W-1:0]   dv_shade_q;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_height_r <= HEIGHT_BITS'(wcs_pkg::SCREEN_HEIGHT_RST);
      height_margin_r <= HEIGHT_BITS'(wcs_pkg::HEIGHT_MARGIN_RST);
      height_gain_r   <= wcs_pkg::HEIGHT_GAIN_RST;
      shade_gain_r    <= wcs_pkg::SHADE_GAIN_RST;
      min_shade_r     <= wcs_pkg::MIN_SHADE_RST;
      view_limit_r    <= wcs_pkg::VIEW_LIMIT_RST;
    end else if (cfg_we) begin
      case (wcs_pkg::cfg_idx_t'(cfg_index))
        wcs_pkg::CFG_SCREEN_HEIGHT: begin
          screen_height_r <= cfg_wdata[HEIGHT_BITS-1:0];
        end
        wcs_pkg::CFG_HEIGHT_MARGIN: begin
          height_margin_r <= cfg_wdata[HEIGHT_BITS-1:0];
        end
        wcs_pkg::CFG_HEIGHT_GAIN: begin
          height_gain_r <= cfg_wdata[wcs_pkg::GAIN_W-1:0];
        end
        wcs_pkg::CFG_SHADE_GAIN: begin
          shade_gain_r <= cfg_wdata[wcs_pkg::GAIN_W-1:0];
        end
        wcs_pkg::CFG_MIN_SHADE: begin
          min_shade_r <= cfg_wdata[wcs_pkg::SHADE_W-1:0];
        end
        wcs_pkg::CFG_VIEW_LIMIT: begin
          view_limit_r <= cfg_wdata[wcs_pkg::DIST_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Busy only while coming out of reset; afterwards every cycle with start high takes an item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign in_acc = start && !busy_r;

  wcs_front #(
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_acc),
    .in_cell_code  (in_cell_code),
    .in_side_hit   (in_side_hit),
    .in_distance   (in_distance),
    .screen_height (screen_height_r),
    .height_gain   (height_gain_r),
    .shade_gain    (shade_gain_r),
    .view_limit    (view_limit_r),
    .out_valid     (fr_valid),
    .out_tag       (fr_tag),
    .out_distance  (fr_distance),
    .out_num       (fr_num)
  );

  wcs_div_pipe #(
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (fr_valid),
    .in_tag       (fr_tag),
    .in_distance  (fr_distance),
    .in_num       (fr_num),
    .shade_gain   (shade_gain_r),
    .out_valid    (dv_valid),
    .out_tag      (dv_tag),
    .out_height_q (dv_height_q),
    .out_shade_q  (dv_shade_q)
  );

  wcs_back #(
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (dv_valid),
    .in_tag            (dv_tag),
    .in_height_q       (dv_height_q),
    .in_shade_q        (dv_shade_q),
    .screen_height     (screen_height_r),
    .height_margin     (height_margin_r),
    .min_shade         (min_shade_r),
    .out_valid         (out_valid),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_column_height (out_column_height)
  );

`ifndef NO_ASSERTIONS
  // Every accepted item yields its result.
  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##LATENCY out_valid)
    else $error("accepted item produced no result");

  // No result appears without an accepted item.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |-> ##LATENCY !out_valid)
    else $error("result without an accepted item");

  // A column is either the full screen height or clamped into [2, screen].
  a_height_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_column_height == screen_height_r) ||
                  (out_column_height == HEIGHT_BITS'(wcs_pkg::HEIGHT_MIN)) ||
                  ((out_column_height > HEIGHT_BITS'(wcs_pkg::HEIGHT_MIN)) &&
                   (out_column_height <= screen_height_r)))
    else $error("column height outside its clamp range");

  // Reset flushes the result strobe.
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe survived reset");
`endif

endmodule
